FILE: design/dnes_pkg.sv
package dnes_pkg;

  localparam int ExpW     = 24;
  localparam int ToneW    = 8;
  localparam int TempW    = 16;
  localparam int JitW     = 7;
  localparam int DwellW   = 9;
  localparam int HoldW    = 8;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 24;
  localparam int ScaleW   = ExpW + 7;
  localparam int BoundW   = ExpW + JitW + 1;

  localparam logic [6:0]        JitterScale        = 7'd100;
  localparam logic [HoldW-1:0]  HOLD_TICKS_DEFAULT = 8'd3;
  localparam logic [DwellW-1:0] DWELL_MAX          = '1;

  typedef enum logic [2:0] {
    EV_STEADY   = 3'd0,
    EV_JITTER   = 3'd1,
    EV_HOLDOFF  = 3'd2,
    EV_TO_NIGHT = 3'd3,
    EV_DAY_ONE  = 3'd4,
    EV_DAY_TWO  = 3'd5
  } event_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_JITTER_TOL     = 3'd0,
    REG_NIGHT_EXPOSURE = 3'd1,
    REG_DAY_EXPOSURE   = 3'd2,
    REG_DAY_TONE       = 3'd3,
    REG_DAY_DWELL      = 3'd4,
    REG_WARM_TEMP      = 3'd5,
    REG_WARM_TONE      = 3'd6,
    REG_WARM_DWELL     = 3'd7
  } cfg_reg_t;

  typedef enum logic {
    MODE_DAY   = 1'b0,
    MODE_NIGHT = 1'b1
  } mode_t;

  typedef struct packed {
    logic [JitW-1:0]  jitter_tol;
    logic [ExpW-1:0]  night_exposure_limit;
    logic [ExpW-1:0]  day_exposure_limit;
    logic [ToneW-1:0] day_tone_limit;
    logic [7:0]       day_dwell_limit;
    logic [TempW-1:0] warm_temp_limit;
    logic [ToneW-1:0] warm_tone_limit;
    logic [7:0]       warm_dwell_limit;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    jitter_tol:           7'd3,
    night_exposure_limit: 24'd1200000,
    day_exposure_limit:   24'd930000,
    day_tone_limit:       8'd14,
    day_dwell_limit:      8'd10,
    warm_temp_limit:      16'd3000,
    warm_tone_limit:      8'd17,
    warm_dwell_limit:     8'd8
  };

  typedef struct packed {
    logic [ExpW-1:0]  exposure;
    logic [ToneW-1:0] tone_strength;
    logic [TempW-1:0] color_temp;
    logic             jitter;
  } sample_t;

  typedef struct packed {
    logic   night_mode;
    logic   mode_changed;
    event_t event_code;
  } result_t;

endpackage

FILE: design/dnes_if.sv
interface dnes_sample_if import dnes_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ExpW-1:0]  exposure;
  logic [ToneW-1:0] tone_strength;
  logic [TempW-1:0] color_temp;

  modport source (output valid, output exposure, output tone_strength, output color_temp,
                  input ready);
  modport sink (input valid, input exposure, input tone_strength, input color_temp,
                output ready);
endinterface

interface dnes_result_if import dnes_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       night_mode;
  logic       mode_changed;
  logic [2:0] event_code;

  modport source (output valid, output night_mode, output mode_changed, output event_code,
                  input ready);
  modport sink (input valid, input night_mode, input mode_changed, input event_code,
                output ready);
endinterface

FILE: design/dnes_jitter.sv
module dnes_jitter import dnes_pkg::*; (
  input  logic [ExpW-1:0] exposure,
  input  logic [ExpW-1:0] previous,
  input  logic [JitW-1:0] jitter_tol,
  output logic            jitter
);

  logic [ExpW-1:0]   delta;
  logic [JitW:0]     percent_plus;
  logic [ScaleW-1:0] scaled_delta;
  logic [BoundW-1:0] bound;

  assign delta        = (exposure >= previous) ? exposure - previous : previous - exposure;
  assign percent_plus = {1'b0, jitter_tol} + {{JitW{1'b0}}, 1'b1};
  assign scaled_delta = ScaleW'(delta) * ScaleW'(JitterScale);
  assign bound        = BoundW'(percent_plus) * BoundW'(exposure);

  assign jitter = (delta != '0) && (BoundW'(scaled_delta) >= bound);

endmodule

FILE: design/dnes_mode.sv
module dnes_mode import dnes_pkg::*; #(
  parameter logic [HoldW-1:0] HOLD_TICKS = HOLD_TICKS_DEFAULT
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  sample_t smp,
  input  cfg_t    cfg,
  output result_t res
);

  mode_t              mode;
  mode_t              mode_next;
  logic [HoldW-1:0]   holdoff;
  logic [HoldW-1:0]   holdoff_next;
  logic [DwellW-1:0]  dwell_one;
  logic [DwellW-1:0]  dwell_one_next;
  logic [DwellW-1:0]  dwell_two;
  logic [DwellW-1:0]  dwell_two_next;
  logic [DwellW-1:0]  one_inc;
  logic [DwellW-1:0]  two_inc;
  logic               quiet;
  logic               to_night;
  logic               rule_one;
  logic               rule_two;
  logic               fire_one;
  logic               fire_two;
  event_t             event_code;

  assign one_inc  = (dwell_one == DWELL_MAX) ? dwell_one : dwell_one + 1'b1;
  assign two_inc  = (dwell_two == DWELL_MAX) ? dwell_two : dwell_two + 1'b1;
  assign quiet    = !smp.jitter && (holdoff == '0);
  assign to_night = quiet && (mode == MODE_DAY) &&
                    (smp.exposure > cfg.night_exposure_limit);
  assign rule_one = (mode == MODE_NIGHT) && (smp.exposure < cfg.day_exposure_limit) &&
                    (smp.tone_strength < cfg.day_tone_limit);
  assign rule_two = (mode == MODE_NIGHT) && (smp.color_temp < cfg.warm_temp_limit) &&
                    (smp.tone_strength > cfg.warm_tone_limit);
  assign fire_one = quiet && rule_one && (one_inc > {1'b0, cfg.day_dwell_limit});
  assign fire_two = quiet && !fire_one && rule_two &&
                    (two_inc > {1'b0, cfg.warm_dwell_limit});

  always_comb begin
    mode_next = mode;
    case (mode)
      MODE_DAY: begin
        if (to_night) begin
          mode_next = MODE_NIGHT;
        end
      end
      MODE_NIGHT: begin
        if (fire_one || fire_two) begin
          mode_next = MODE_DAY;
        end
      end
      default: mode_next = MODE_DAY;
    endcase
  end

  always_comb begin
    holdoff_next   = holdoff;
    dwell_one_next = dwell_one;
    dwell_two_next = dwell_two;
    event_code     = EV_STEADY;
    if (smp.jitter) begin
      dwell_one_next = '0;
      dwell_two_next = '0;
      event_code     = EV_JITTER;
    end else if (holdoff != '0) begin
      holdoff_next = holdoff - 1'b1;
      event_code   = EV_HOLDOFF;
    end else if (to_night) begin
      dwell_one_next = '0;
      dwell_two_next = '0;
      holdoff_next   = HOLD_TICKS;
      event_code     = EV_TO_NIGHT;
    end else begin
      dwell_one_next = rule_one ? one_inc : '0;
      if (fire_one) begin
        holdoff_next = HOLD_TICKS;
        event_code   = EV_DAY_ONE;
      end else begin
        dwell_two_next = rule_two ? two_inc : '0;
        if (fire_two) begin
          holdoff_next = HOLD_TICKS;
          event_code   = EV_DAY_TWO;
        end
      end
    end
  end

  assign res.night_mode   = (mode_next == MODE_NIGHT);
  assign res.mode_changed = (mode_next != mode);
  assign res.event_code   = event_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_DAY;
      holdoff   <= HOLD_TICKS;
      dwell_one <= '0;
      dwell_two <= '0;
    end else if (step) begin
      mode      <= mode_next;
      holdoff   <= holdoff_next;
      dwell_one <= dwell_one_next;
      dwell_two <= dwell_two_next;
    end
  end

endmodule

FILE: design/day_night_exposure_switch.sv
// Channel   Direction  Payload                                  Handshake
// sample    in         exposure, tone_strength, color_temp      valid/ready
// result    out        night_mode, mode_changed, event_code     valid/ready
// cfg       in         cfg_index, cfg_data                      cfg_write
//
// A transaction is accepted every cycle that sample.ready is high; its result is registered.
// The sample sits in an input register, and the jitter test and the mode update are
// combinational between it and the result register.
// Reset is synchronous and clears all control state, but not the sample and result data.
// A stall holds the result and any full input; sample.ready falls only when both are full.
module day_night_exposure_switch import dnes_pkg::*; #(
  parameter logic [HoldW-1:0] HOLD_TICKS = HOLD_TICKS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  dnes_sample_if.sink         sample,
  dnes_result_if.source       result,
  input  logic                cfg_write,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  cfg_t             cfg;
  logic             s1_valid;
  logic             s1_en;
  logic [ExpW-1:0]  s1_exposure;
  logic [ToneW-1:0] s1_tone;
  logic [TempW-1:0] s1_temp;
  logic [ExpW-1:0]  s1_previous;
  logic [ExpW-1:0]  previous_exposure;
  logic             s1_jitter;
  logic             out_valid;
  logic             out_en;
  result_t          out_result;
  result_t          res_next;
  sample_t          smp;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_JITTER_TOL:     cfg.jitter_tol           <= cfg_data[JitW-1:0];
        REG_NIGHT_EXPOSURE: cfg.night_exposure_limit <= cfg_data[ExpW-1:0];
        REG_DAY_EXPOSURE:   cfg.day_exposure_limit   <= cfg_data[ExpW-1:0];
        REG_DAY_TONE:       cfg.day_tone_limit       <= cfg_data[ToneW-1:0];
        REG_DAY_DWELL:      cfg.day_dwell_limit      <= cfg_data[7:0];
        REG_WARM_TEMP:      cfg.warm_temp_limit      <= cfg_data[TempW-1:0];
        REG_WARM_TONE:      cfg.warm_tone_limit      <= cfg_data[ToneW-1:0];
        REG_WARM_DWELL:     cfg.warm_dwell_limit     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign out_en       = !out_valid || result.ready;
  assign s1_en        = !s1_valid || out_en;
  assign sample.ready = s1_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid          <= 1'b0;
      out_valid         <= 1'b0;
      previous_exposure <= '0;
    end else begin
      if (s1_en) begin
        s1_valid <= sample.valid;
        if (sample.valid) begin
          previous_exposure <= sample.exposure;
        end
      end
      if (out_en) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en && sample.valid) begin
      s1_exposure <= sample.exposure;
      s1_tone     <= sample.tone_strength;
      s1_temp     <= sample.color_temp;
      s1_previous <= previous_exposure;
    end
    if (out_en && s1_valid) begin
      out_result <= res_next;
    end
  end

  dnes_jitter u_jitter (
    .exposure   (s1_exposure),
    .previous   (s1_previous),
    .jitter_tol (cfg.jitter_tol),
    .jitter     (s1_jitter)
  );

  assign smp.exposure      = s1_exposure;
  assign smp.tone_strength = s1_tone;
  assign smp.color_temp    = s1_temp;
  assign smp.jitter        = s1_jitter;

  dnes_mode #(
    .HOLD_TICKS (HOLD_TICKS)
  ) u_mode (
    .clk  (clk),
    .rst  (rst),
    .step (s1_valid && out_en),
    .smp  (smp),
    .cfg  (cfg),
    .res  (res_next)
  );

  assign result.valid        = out_valid;
  assign result.night_mode   = out_result.night_mode;
  assign result.mode_changed = out_result.mode_changed;
  assign result.event_code   = out_result.event_code;

endmodule

FILE: design/dnes_checker.sv
module dnes_checker import dnes_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic       night_mode,
  input logic       mode_changed,
  input logic [2:0] event_code
);

  logic last_mode;
  logic res_accept;
  logic switch_event;

  assign res_accept   = res_valid && res_ready;
  assign switch_event = (event_code == EV_TO_NIGHT) || (event_code == EV_DAY_ONE) ||
                        (event_code == EV_DAY_TWO);

  always_ff @(posedge clk) begin
    if (rst) begin
      last_mode <= 1'b0;
    end else if (res_accept) begin
      last_mode <= night_mode;
    end
  end

  // A mode switch is reported exactly when the event names one.
  a_switch_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (mode_changed == switch_event))
    else $error("mode_changed disagrees with event_code");

  // The direction of a switch matches its event.
  a_switch_dir: assert property (@(posedge clk) disable iff (rst)
    res_valid && switch_event |-> (night_mode == (event_code == EV_TO_NIGHT)))
    else $error("switch direction disagrees with event_code");

  // Delivered results form a consistent chain of modes.
  a_mode_chain: assert property (@(posedge clk) disable iff (rst)
    res_accept |-> (night_mode == (last_mode ^ mode_changed)))
    else $error("result mode does not follow the previous result");

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(night_mode) &&
      $stable(mode_changed) && $stable(event_code))
    else $error("stalled result changed");

  // No result is offered right after reset.
  a_reset: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

bind day_night_exposure_switch dnes_checker u_dnes_checker (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (result.valid),
  .res_ready    (result.ready),
  .night_mode   (result.night_mode),
  .mode_changed (result.mode_changed),
  .event_code   (result.event_code)
);

FILE: dv/day_night_exposure_switch_tb.sv
`timescale 1ns / 100ps

module day_night_exposure_switch_tb;
  import dnes_pkg::*;

  typedef struct {
    bit                  is_write;
    cfg_reg_t            reg_sel;
    logic [CfgDataW-1:0] wdata;
    logic [ExpW-1:0]     exposure;
    logic [ToneW-1:0]    tone;
    logic [TempW-1:0]    temp;
    bit                  typed;
    result_t             want;
  } stim_row_t;

  logic                clk;
  logic                rst;
  logic                cfg_write;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  dnes_sample_if sample();
  dnes_result_if result();

  day_night_exposure_switch dut (
    .clk(clk),
    .rst(rst),
    .sample(sample),
    .result(result),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  cfg_t              shadow_cfg;
  mode_t             predicted_mode;
  logic [ExpW-1:0]   model_prev_exp;
  logic [HoldW-1:0]  holdoff_left;
  logic [DwellW-1:0] dim_dwell;
  logic [DwellW-1:0] warm_dwell;
  result_t           pending_results[$];
  stim_row_t         directed_rows[$];
  int                errors;
  bit                offer_typed;
  result_t           offer_want;
  bit                sender_gaps;
  bit                receiver_stalls;
  bit                long_hold_req;
  logic [ExpW-1:0]   level;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic void apply_cfg(cfg_reg_t sel, logic [CfgDataW-1:0] d);
    case (sel)
      REG_JITTER_TOL:     shadow_cfg.jitter_tol = d[JitW-1:0];
      REG_NIGHT_EXPOSURE: shadow_cfg.night_exposure_limit = d[ExpW-1:0];
      REG_DAY_EXPOSURE:   shadow_cfg.day_exposure_limit = d[ExpW-1:0];
      REG_DAY_TONE:       shadow_cfg.day_tone_limit = d[ToneW-1:0];
      REG_DAY_DWELL:      shadow_cfg.day_dwell_limit = d[7:0];
      REG_WARM_TEMP:      shadow_cfg.warm_temp_limit = d[TempW-1:0];
      REG_WARM_TONE:      shadow_cfg.warm_tone_limit = d[ToneW-1:0];
      REG_WARM_DWELL:     shadow_cfg.warm_dwell_limit = d[7:0];
      default: ;
    endcase
  endfunction

  function automatic result_t step_mode(logic [ExpW-1:0] e, logic [ToneW-1:0] tn,
                                        logic [TempW-1:0] ct);
    logic [ExpW-1:0] delta;
    logic [39:0]     scaled_delta;
    logic [39:0]     bound;
    logic            jitter;
    logic            fired;
    mode_t           was;
    event_t          ev;
    result_t         r;
    was = predicted_mode;
    ev = EV_STEADY;
    fired = 1'b0;
    delta = (e >= model_prev_exp) ? e - model_prev_exp : model_prev_exp - e;
    scaled_delta = 40'(delta) * 40'd100;
    bound = (40'(shadow_cfg.jitter_tol) + 40'd1) * 40'(e);
    jitter = (delta != 0) && (scaled_delta >= bound);
    model_prev_exp = e;
    if (jitter) begin
      dim_dwell = '0;
      warm_dwell = '0;
      ev = EV_JITTER;
    end else if (holdoff_left != 0) begin
      holdoff_left = holdoff_left - 1'b1;
      ev = EV_HOLDOFF;
    end else if (predicted_mode == MODE_DAY && e > shadow_cfg.night_exposure_limit) begin
      dim_dwell = '0;
      warm_dwell = '0;
      predicted_mode = MODE_NIGHT;
      holdoff_left = HOLD_TICKS_DEFAULT;
      ev = EV_TO_NIGHT;
    end else begin
      if (predicted_mode == MODE_NIGHT && e < shadow_cfg.day_exposure_limit &&
          tn < shadow_cfg.day_tone_limit) begin
        if (dim_dwell != DWELL_MAX) dim_dwell = dim_dwell + 1'b1;
        if (dim_dwell > shadow_cfg.day_dwell_limit) begin
          predicted_mode = MODE_DAY;
          holdoff_left = HOLD_TICKS_DEFAULT;
          ev = EV_DAY_ONE;
          fired = 1'b1;
        end
      end else begin
        dim_dwell = '0;
      end
      if (!fired) begin
        if (predicted_mode == MODE_NIGHT && ct < shadow_cfg.warm_temp_limit &&
            tn > shadow_cfg.warm_tone_limit) begin
          if (warm_dwell != DWELL_MAX) warm_dwell = warm_dwell + 1'b1;
          if (warm_dwell > shadow_cfg.warm_dwell_limit) begin
            predicted_mode = MODE_DAY;
            holdoff_left = HOLD_TICKS_DEFAULT;
            ev = EV_DAY_TWO;
          end
        end else begin
          warm_dwell = '0;
        end
      end
    end
    r.night_mode = predicted_mode;
    r.mode_changed = (predicted_mode != was);
    r.event_code = ev;
    return r;
  endfunction

  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic stim_row_t reg_row(cfg_reg_t sel, logic [CfgDataW-1:0] d);
    stim_row_t r;
    r.is_write = 1'b1;
    r.reg_sel = sel;
    r.wdata = d;
    r.exposure = '0;
    r.tone = '0;
    r.temp = '0;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic stim_row_t sample_row(logic [ExpW-1:0] e, logic [ToneW-1:0] tn,
                                           logic [TempW-1:0] ct);
    stim_row_t r;
    r = reg_row(REG_JITTER_TOL, '0);
    r.is_write = 1'b0;
    r.exposure = e;
    r.tone = tn;
    r.temp = ct;
    return r;
  endfunction

  function automatic stim_row_t known_row(logic [ExpW-1:0] e, logic [ToneW-1:0] tn,
                                          logic [TempW-1:0] ct, logic night, logic changed,
                                          event_t ev);
    stim_row_t r;
    r = sample_row(e, tn, ct);
    r.typed = 1'b1;
    r.want.night_mode = night;
    r.want.mode_changed = changed;
    r.want.event_code = ev;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t seen;
    result_t due;
    if (!rst) begin
      if (sample.valid && sample.ready) begin
        due = step_mode(sample.exposure, sample.tone_strength, sample.color_temp);
        pending_results.push_back(offer_typed ? offer_want : due);
      end
      if (result.valid && result.ready) begin
        seen.night_mode = result.night_mode;
        seen.mode_changed = result.mode_changed;
        seen.event_code = event_t'(result.event_code);
        if (pending_results.size() == 0) begin
          if (errors < 40)
            $display("%0t ns: unexpected result night_mode=%0b mode_changed=%0b event_code=%0d",
                     $time, seen.night_mode, seen.mode_changed, seen.event_code);
          errors++;
        end else begin
          due = pending_results.pop_front();
          if (seen.night_mode !== due.night_mode || seen.mode_changed !== due.mode_changed ||
              seen.event_code !== due.event_code) begin
            if (errors < 40)
              $display("%0t ns: expected %0b/%0b/%0d got %0b/%0b/%0d",
                       $time, due.night_mode, due.mode_changed, due.event_code,
                       seen.night_mode, seen.mode_changed, seen.event_code);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    int hold_left;
    hold_left = 0;
    result.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        hold_left = 60;
        long_hold_req = 1'b0;
      end else if (hold_left == 0 && receiver_stalls && $urandom_range(0, 3) == 0) begin
        hold_left = idle_span();
      end
      if (hold_left > 0) begin
        result.ready = 1'b0;
        hold_left--;
      end else begin
        result.ready = 1'b1;
      end
    end
  end

  task automatic send_sample(logic [ExpW-1:0] e, logic [ToneW-1:0] tn, logic [TempW-1:0] ct,
                             bit typed, result_t want);
    int gap;
    gap = sender_gaps ? idle_span() : 0;
    repeat (gap) begin
      @(negedge clk);
      sample.valid = 1'b0;
    end
    @(negedge clk);
    sample.valid = 1'b1;
    sample.exposure = e;
    sample.tone_strength = tn;
    sample.color_temp = ct;
    offer_typed = typed;
    offer_want = want;
    do @(posedge clk); while (!sample.ready);
  endtask

  task automatic settle();
    int guard;
    guard = 0;
    @(negedge clk);
    sample.valid = 1'b0;
    while (pending_results.size() != 0 && guard < 20000) begin
      @(negedge clk);
      guard++;
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t sel, logic [CfgDataW-1:0] d);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = sel;
    cfg_data = d;
    @(negedge clk);
    cfg_write = 1'b0;
    apply_cfg(sel, d);
  endtask

  initial begin
    int                  p;
    int                  n;
    logic [CfgDataW-1:0] v[8];
    logic [ExpW-1:0]     e;
    logic [ExpW-1:0]     jitter_span;
    logic [ExpW:0]       wide;
    logic [ToneW-1:0]    tn;
    logic [TempW-1:0]    ct;
    result_t             none;

    none = '0;
    errors = 0;
    shadow_cfg = CFG_RESET;
    predicted_mode = MODE_DAY;
    model_prev_exp = '0;
    holdoff_left = HOLD_TICKS_DEFAULT;
    dim_dwell = '0;
    warm_dwell = '0;
    offer_typed = 1'b0;
    offer_want = '0;
    sender_gaps = 1'b1;
    receiver_stalls = 1'b1;
    long_hold_req = 1'b0;
    sample.valid = 1'b0;
    sample.exposure = '0;
    sample.tone_strength = '0;
    sample.color_temp = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    rst = 1'b1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    directed_rows.push_back(known_row(0, 0, 0, 1'b0, 1'b0, EV_HOLDOFF));
    directed_rows.push_back(known_row(1000, 0, 0, 1'b0, 1'b0, EV_JITTER));
    directed_rows.push_back(known_row(1000, 0, 0, 1'b0, 1'b0, EV_HOLDOFF));
    directed_rows.push_back(known_row(1000, 0, 0, 1'b0, 1'b0, EV_HOLDOFF));
    directed_rows.push_back(known_row(1000, 0, 0, 1'b0, 1'b0, EV_STEADY));
    directed_rows.push_back(sample_row(1041, 20, 2000));
    directed_rows.push_back(known_row(0, 0, 0, 1'b0, 1'b0, EV_JITTER));
    directed_rows.push_back(known_row(0, 0, 0, 1'b0, 1'b0, EV_STEADY));
    directed_rows.push_back(reg_row(REG_JITTER_TOL, 24'hFFFFFF));
    directed_rows.push_back(known_row(24'hFFFFFF, 8'hFF, 16'hFFFF, 1'b1, 1'b1, EV_TO_NIGHT));
    repeat (3)
      directed_rows.push_back(known_row(24'hFFFFFF, 8'hFF, 16'hFFFF, 1'b1, 1'b0, EV_HOLDOFF));
    directed_rows.push_back(reg_row(REG_DAY_DWELL, 0));
    directed_rows.push_back(reg_row(REG_DAY_EXPOSURE, 24'hFFFFFF));
    directed_rows.push_back(reg_row(REG_DAY_TONE, 8'hFF));
    directed_rows.push_back(known_row(100, 0, 16'hFFFF, 1'b1, 1'b0, EV_JITTER));
    directed_rows.push_back(known_row(100, 0, 16'hFFFF, 1'b0, 1'b1, EV_DAY_ONE));
    repeat (3) directed_rows.push_back(known_row(100, 0, 16'hFFFF, 1'b0, 1'b0, EV_HOLDOFF));
    directed_rows.push_back(reg_row(REG_NIGHT_EXPOSURE, 0));
    directed_rows.push_back(reg_row(REG_DAY_TONE, 0));
    directed_rows.push_back(reg_row(REG_WARM_TEMP, 16'hFFFF));
    directed_rows.push_back(reg_row(REG_WARM_TONE, 0));
    directed_rows.push_back(reg_row(REG_WARM_DWELL, 0));
    directed_rows.push_back(known_row(1, 1, 0, 1'b0, 1'b0, EV_JITTER));
    directed_rows.push_back(known_row(1, 1, 0, 1'b1, 1'b1, EV_TO_NIGHT));
    repeat (3) directed_rows.push_back(known_row(1, 1, 0, 1'b1, 1'b0, EV_HOLDOFF));
    directed_rows.push_back(known_row(1, 1, 0, 1'b0, 1'b1, EV_DAY_TWO));

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_write) begin
        settle();
        write_reg(directed_rows[i].reg_sel, directed_rows[i].wdata);
      end else begin
        send_sample(directed_rows[i].exposure, directed_rows[i].tone, directed_rows[i].temp,
                    directed_rows[i].typed, directed_rows[i].want);
      end
    end

    for (p = 0; p < 7; p++) begin
      settle();
      case (p)
        0: foreach (v[i]) v[i] = '0;
        1: foreach (v[i]) v[i] = 24'hFFFFFF;
        2: begin
          v[0] = 100;
          v[1] = 0;
          v[2] = 24'hFFFFFF;
          v[3] = 8'hFF;
          v[4] = 0;
          v[5] = 16'hFFFF;
          v[6] = 0;
          v[7] = 8'hFF;
        end
        default: begin
          v[0] = CfgDataW'(($urandom & 24'hFFFF80) |
                 (($urandom_range(0, 9) == 0) ? $urandom_range(101, 127)
                                              : $urandom_range(0, 100)));
          v[1] = CfgDataW'($urandom);
          v[2] = CfgDataW'($urandom);
          v[3] = CfgDataW'($urandom);
          v[4] = CfgDataW'(($urandom_range(0, 3) == 0) ? $urandom
                           : ($urandom & 24'hFFFF00) | $urandom_range(0, 12));
          v[5] = CfgDataW'($urandom);
          v[6] = CfgDataW'($urandom);
          v[7] = CfgDataW'(($urandom_range(0, 3) == 0) ? $urandom
                           : ($urandom & 24'hFFFF00) | $urandom_range(0, 12));
        end
      endcase
      foreach (v[i]) write_reg(cfg_reg_t'(i), v[i]);
      sender_gaps = (p % 3 != 2);
      receiver_stalls = (p % 3 != 1);
      if (p == 4) begin
        sender_gaps = 1'b0;
        long_hold_req = 1'b1;
      end
      level = ExpW'($urandom);
      for (n = 0; n < 250; n++) begin
        if ($urandom_range(0, 24) == 0) begin
          case ($urandom_range(0, 5))
            0: level = ExpW'($urandom_range(0, shadow_cfg.day_exposure_limit));
            1: begin
              wide = (ExpW+1)'(shadow_cfg.night_exposure_limit + 1 + $urandom_range(0, 2000));
              level = wide[ExpW] ? 24'hFFFFFF : wide[ExpW-1:0];
            end
            2: level = ExpW'($urandom);
            3: level = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h0;
            4: level = ExpW'($urandom_range(0, 255));
            default: level = ExpW'($urandom_range(0, shadow_cfg.night_exposure_limit));
          endcase
        end
        jitter_span = level >> 8;
        case ($urandom_range(0, 3))
          1: begin
            wide = (ExpW+1)'(level + $urandom_range(0, jitter_span));
            e = wide[ExpW] ? 24'hFFFFFF : wide[ExpW-1:0];
          end
          2: e = ExpW'(level - $urandom_range(0, jitter_span));
          default: e = level;
        endcase
        if ($urandom_range(0, 29) == 0) e = ExpW'($urandom);
        case ($urandom_range(0, 3))
          0: tn = (shadow_cfg.day_tone_limit == 0) ? 8'd0
                  : ToneW'($urandom_range(0, shadow_cfg.day_tone_limit - 1));
          1: tn = (shadow_cfg.warm_tone_limit == 8'hFF) ? 8'hFF
                  : ToneW'($urandom_range(shadow_cfg.warm_tone_limit + 1, 255));
          default: tn = ToneW'($urandom);
        endcase
        if ($urandom_range(0, 9) < 7 && shadow_cfg.warm_temp_limit != 0)
          ct = TempW'($urandom_range(0, shadow_cfg.warm_temp_limit - 1));
        else
          ct = TempW'($urandom);
        send_sample(e, tn, ct, 1'b0, none);
      end
    end

    settle();
    if (pending_results.size() != 0) begin
      $display("%0t ns: %0d expected results never arrived", $time, pending_results.size());
      errors += pending_results.size();
    end
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: sim.f
design/dnes_pkg.sv
design/dnes_if.sv
design/dnes_jitter.sv
design/dnes_mode.sv
design/day_night_exposure_switch.sv
design/dnes_checker.sv
dv/day_night_exposure_switch_tb.sv
